// ===== hdl/slpm_pkg.sv =====
// slpm_pkg: shared types and constants of the sql like pattern matcher
// item kinds, wildcard bytes, cell and result structs
// no dependencies
package slpm_pkg;

  // default capacity of the pattern store, in bytes
  localparam int PATTERN_MAX_DEF = 32;

  // wildcard bytes
  localparam logic [7:0] CH_ANY_RUN = 8'h25;  // '%'
  localparam logic [7:0] CH_ANY_ONE = 8'h5F;  // '_'

  // item kinds carried on in_tuser; codes five to seven are ignored
  typedef enum logic [2:0] {
    FUNC_PAT_APPEND = 3'd0,
    FUNC_SUBJECT    = 3'd1,
    FUNC_EMPTY_ROW  = 3'd2,
    FUNC_NULL_ROW   = 3'd3,
    FUNC_PAT_CLEAR  = 3'd4
  } func_t;

  // what one cell reports for its pattern position
  typedef struct packed {
    logic stay;  // live '%' position keeps itself alive
    logic fwd;   // live position consumed the byte, next position goes live
    logic pct;   // position holds a '%' inside the stored pattern
  } cell_out_t;

  // one result beat
  typedef struct packed {
    logic pattern_overflow;
    logic matched;
  } result_t;

endpackage

// ===== hdl/sql_like_pattern_match.sv =====
// sql_like_pattern_match: top level of the streaming sql like matcher
// row of slpm_cell pattern positions, slpm_closure wildcard spreader, output skid
// depends on slpm_pkg, slpm_cell, slpm_closure
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------------
//  in      | sink      | in_tvalid/in_tready  | tdata byte_value, tuser func, tlast last
//  out     | source    | out_tvalid/out_tready| tdata[0] matched, tuser pattern_overflow
//  cfg     | sink      | cfg_valid/cfg_ready  | cfg_data invert_result
//
// one input beat per cycle while in_tready is high; a row result is registered
// the rate is set by the position update: cell compare plus one closure add
// reset empties the pattern and the overflow flag, clears invert_result and the result buffer
// a stalled output fills a one-beat skid stage; in_tready drops only while the skid is full
// cfg_ready is always high; a write lands at the edge where cfg_valid is high
module sql_like_pattern_match #(
  parameter int PATTERN_MAX = slpm_pkg::PATTERN_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  // input stream
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] byte_value
  input  logic [2:0] in_tuser,   // [2:0] func
  input  logic       in_tlast,   // last
  // result stream
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [0] matched, [7:1] zero
  output logic       out_tuser,  // [0] pattern_overflow
  // configuration
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data    // invert_result
);

  localparam int LEN_W = $clog2(PATTERN_MAX + 1);
  localparam int POS_W = PATTERN_MAX + 1;
  localparam logic [POS_W-1:0] START_POS = {{PATTERN_MAX{1'b0}}, 1'b1};

  // tracker state: live positions before closure, pattern bookkeeping
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [POS_W-1:0] tail_r, tail_nxt;   // trailing run of '%' in the pattern
  logic             ovf_r, ovf_nxt;
  logic             invert_r;

  // result buffer: output register plus skid
  slpm_pkg::result_t out_r, out_nxt, skid_r, skid_nxt;
  logic              out_valid_r, out_valid_nxt, skid_valid_r, skid_valid_nxt;

  logic              in_acc;
  slpm_pkg::func_t   func;
  logic              full;
  logic              produce;
  logic              row_valid;
  logic              hit;
  slpm_pkg::result_t new_res;

  logic [PATTERN_MAX-1:0] cell_en;
  logic [PATTERN_MAX-1:0] cell_wr;
  logic [PATTERN_MAX-1:0] pct_vec;
  slpm_pkg::cell_out_t    cell_q [PATTERN_MAX];
  logic [POS_W-1:0]       len_onehot;
  logic [POS_W-1:0]       pct_mask;
  logic [POS_W-1:0]       active;
  logic [POS_W-1:0]       pre;
  logic [POS_W-1:0]       end_mask;

  assign in_tready = ~skid_valid_r;
  assign in_acc    = in_tvalid & in_tready;
  assign func      = slpm_pkg::func_t'(in_tuser);
  assign full      = (len_r == LEN_W'(PATTERN_MAX));
  assign cfg_ready = 1'b1;

  // closed set of live positions for the current beat
  assign pct_mask = {1'b0, pct_vec};

  slpm_closure #(.W(POS_W)) u_closure (
    .s (pos_r),
    .p (pct_mask),
    .a (active)
  );

  // row of pattern positions
  genvar gi;
  generate
    for (gi = 0; gi < PATTERN_MAX; gi++) begin : g_cell
      assign cell_en[gi] = (LEN_W'(gi) < len_r);
      assign cell_wr[gi] = in_acc & (func == slpm_pkg::FUNC_PAT_APPEND) &
                           (len_r == LEN_W'(gi));
      slpm_cell u_cell (
        .clk     (clk),
        .wr_en   (cell_wr[gi]),
        .wr_byte (in_tdata),
        .en      (cell_en[gi]),
        .act     (active[gi]),
        .subj    (in_tdata),
        .q       (cell_q[gi])
      );
      assign pct_vec[gi] = cell_q[gi].pct;
    end
    for (gi = 0; gi < POS_W; gi++) begin : g_len
      assign len_onehot[gi] = (len_r == LEN_W'(gi));
    end
    // each position is fed by its own '%' loop and/or the match handed over from below
    assign pre[0] = cell_q[0].stay;
    for (gi = 1; gi < PATTERN_MAX; gi++) begin : g_pre
      assign pre[gi] = cell_q[gi].stay | cell_q[gi-1].fwd;
    end
    assign pre[PATTERN_MAX] = cell_q[PATTERN_MAX-1].fwd;
  endgenerate

  // the end position after closure is live if it or any bit of the trailing '%' run is
  assign end_mask = tail_r | len_onehot;

  // tracker and pattern next state
  always_comb begin
    pos_nxt   = pos_r;
    len_nxt   = len_r;
    ovf_nxt   = ovf_r;
    tail_nxt  = tail_r;
    produce   = 1'b0;
    row_valid = 1'b0;
    hit       = 1'b0;
    if (in_acc) begin
      case (func)
        slpm_pkg::FUNC_PAT_APPEND: begin
          pos_nxt = START_POS;
          if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            len_nxt  = len_r + LEN_W'(1);
            tail_nxt = (in_tdata == slpm_pkg::CH_ANY_RUN) ? (tail_r | len_onehot) : '0;
          end
        end
        slpm_pkg::FUNC_SUBJECT: begin
          if (in_tlast) begin
            pos_nxt   = START_POS;
            produce   = 1'b1;
            row_valid = 1'b1;
            hit       = |(pre & end_mask);
          end else begin
            pos_nxt = pre;
          end
        end
        slpm_pkg::FUNC_EMPTY_ROW: begin
          pos_nxt   = START_POS;
          produce   = 1'b1;
          row_valid = 1'b1;
          hit       = end_mask[0];
        end
        slpm_pkg::FUNC_NULL_ROW: begin
          pos_nxt = START_POS;
          produce = 1'b1;
        end
        slpm_pkg::FUNC_PAT_CLEAR: begin
          pos_nxt  = START_POS;
          len_nxt  = '0;
          ovf_nxt  = 1'b0;
          tail_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // null rows and an overflowed pattern give 0 for both polarities
  assign new_res.matched          = row_valid & ~ovf_r & (hit ^ invert_r);
  assign new_res.pattern_overflow = ovf_r;

  // output register and skid
  always_comb begin
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (skid_valid_r) begin
      if (out_tready) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (produce) begin
      if (!out_valid_r || out_tready) begin
        out_nxt       = new_res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = new_res;
        skid_valid_nxt = 1'b1;
      end
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= START_POS;
      len_r        <= '0;
      tail_r       <= '0;
      ovf_r        <= 1'b0;
      invert_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      pos_r        <= pos_nxt;
      len_r        <= len_nxt;
      tail_r       <= tail_nxt;
      ovf_r        <= ovf_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
      if (cfg_valid) begin
        invert_r <= cfg_data;
      end
    end
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_r.matched};
  assign out_tuser  = out_r.pattern_overflow;

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a beat while the output register is empty");

  a_ovf_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.pattern_overflow) |-> !out_r.matched)
    else $error("match reported with an overflowed pattern");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(PATTERN_MAX))
    else $error("pattern length beyond capacity");

  a_clear_takes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (func == slpm_pkg::FUNC_PAT_CLEAR)) |=> (len_r == '0) && !ovf_r && (tail_r == '0))
    else $error("pattern clear did not empty the store");
`endif

endmodule

// ===== hdl/slpm_cell.sv =====
// slpm_cell: one pattern position, holds its byte and wildcard flags
// compares the subject byte and hands the live flag to the next position
// depends on slpm_pkg
module slpm_cell (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [7:0]          wr_byte,
  input  logic                en,
  input  logic                act,
  input  logic [7:0]          subj,
  output slpm_pkg::cell_out_t q
);

  logic [7:0] byte_r;
  logic       pct_r;
  logic       any_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      byte_r <= wr_byte;
      pct_r  <= (wr_byte == slpm_pkg::CH_ANY_RUN);
      any_r  <= (wr_byte == slpm_pkg::CH_ANY_ONE);
    end
  end

  assign q.stay = en & act & pct_r;
  assign q.fwd  = en & act & ~pct_r & (any_r | (byte_r == subj));
  assign q.pct  = en & pct_r;

endmodule

// ===== hdl/slpm_closure.sv =====
// slpm_closure: spreads live positions forward through runs of '%'
// one carry chain: within each run, every bit from the lowest live one up is set
// depends on slpm_pkg for the default width
module slpm_closure #(
  parameter int W = slpm_pkg::PATTERN_MAX_DEF + 1
) (
  input  logic [W-1:0] s,
  input  logic [W-1:0] p,
  output logic [W-1:0] a
);

  logic [W-1:0] run_lo;
  logic [W-1:0] sum;
  logic [W-1:0] fill;

  // bottom bit of each run of '%' positions
  assign run_lo = p & ~(p << 1);
  // carry ripples through the dead low part of each run and stops at its first live bit
  assign sum    = (p & ~s) + run_lo;
  assign fill   = p & (sum | s);
  assign a      = s | (fill << 1);

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// testbench: self-checking bench for sql_like_pattern_match
// drives pattern, subject and row beats, predicts each row result with its own tracker
// depends on slpm_pkg and sql_like_pattern_match
module testbench;

  localparam int PMAX        = slpm_pkg::PATTERN_MAX_DEF;
  localparam int RAND_ITEMS  = 2000;
  localparam int NUM_PHASES  = 8;
  localparam int SETTLE      = 4;    // pipeline plus skid, with margin
  localparam int HOLD_CYCLES = 200;  // long receiver stall, fills the skid
  localparam int DIR_ROWS    = 25;

  // item kinds the block ignores
  localparam logic [2:0] FUNC_RSVD_FIRST = 3'd5;
  localparam logic [2:0] FUNC_RSVD_LAST  = 3'd7;

  // plain literal bytes used to make matches likely
  localparam logic [7:0] CH_A = 8'h61;  // 'a'
  localparam logic [7:0] CH_X = 8'h78;  // 'x'

  // directed row: kind, byte, last flag, repeat count, optional hand-typed result
  typedef struct packed {
    logic [2:0] func;
    logic [7:0] data;
    logic       last;
    logic [7:0] reps;
    logic       typed;
    logic       t_match;
    logic       t_ovf;
  } stim_row_t;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = '0;
  logic [2:0] in_tuser   = slpm_pkg::FUNC_NULL_ROW;
  logic       in_tlast   = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tuser;
  logic       cfg_valid  = 1'b0;
  logic       cfg_ready;
  logic       cfg_data   = 1'b0;

  // predictor state: stored pattern, live positions, overflow and polarity
  logic [7:0]    pat_mem [PMAX];
  int            pat_len;
  logic [PMAX:0] live;
  logic          pat_ovf;
  logic          inv_r;

  slpm_pkg::result_t row_results [$];  // expected row results, oldest first
  int      errors     = 0;
  int      items_sent = 0;
  bit      fast_mode  = 1'b0;  // both sides stop idling
  bit      hold_req   = 1'b0;  // asks the receiver for one long stall

  always #2 clk = ~clk;

  sql_like_pattern_match i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [7:0] byte_value
    .in_tuser   (in_tuser),    // [2:0] func
    .in_tlast   (in_tlast),    // last
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [0] matched, [7:1] zero
    .out_tuser  (out_tuser),   // [0] pattern_overflow
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)     // invert_result
  );

  // directed part; hand-typed results where the answer is obvious
  stim_row_t dir_tbl [DIR_ROWS] = '{
    '{slpm_pkg::FUNC_NULL_ROW,   8'h00, 1'b0, 8'd1,  1'b1, 1'b0, 1'b0},  // null after reset
    '{slpm_pkg::FUNC_EMPTY_ROW,  8'h00, 1'b0, 8'd1,  1'b1, 1'b1, 1'b0},  // empty like empty
    '{slpm_pkg::FUNC_SUBJECT,    8'h00, 1'b1, 8'd1,  1'b1, 1'b0, 1'b0},  // empty pattern
    '{slpm_pkg::FUNC_SUBJECT,    8'hFF, 1'b0, 8'd1,  1'b0, 1'b0, 1'b0},
    '{slpm_pkg::FUNC_NULL_ROW,   8'h00, 1'b0, 8'd1,  1'b1, 1'b0, 1'b0},  // null cuts a row
    '{slpm_pkg::FUNC_PAT_APPEND, slpm_pkg::CH_ANY_RUN, 1'b0, 8'd1, 1'b0, 1'b0, 1'b0},
    '{slpm_pkg::FUNC_PAT_APPEND, CH_A,  1'b0, 8'd1,  1'b0, 1'b0, 1'b0},
    '{slpm_pkg::FUNC_PAT_APPEND, slpm_pkg::CH_ANY_ONE, 1'b0, 8'd1, 1'b0, 1'b0, 1'b0},
    '{slpm_pkg::FUNC_SUBJECT,    CH_X,  1'b0, 8'd1,  1'b0, 1'b0, 1'b0},
    '{slpm_pkg::FUNC_SUBJECT,    CH_A,  1'b0, 8'd1,  1'b0, 1'b0, 1'b0},
    '{slpm_pkg::FUNC_SUBJECT,    8'hFF, 1'b1, 8'd1,  1'b0, 1'b0, 1'b0},
    // literal percent in the subject
    '{slpm_pkg::FUNC_SUBJECT,    slpm_pkg::CH_ANY_RUN, 1'b1, 8'd1, 1'b0, 1'b0, 1'b0},
    '{slpm_pkg::FUNC_SUBJECT,    CH_A,  1'b0, 8'd1,  1'b0, 1'b0, 1'b0},
    '{slpm_pkg::FUNC_PAT_APPEND, 8'h00, 1'b0, 8'd1,  1'b0, 1'b0, 1'b0},  // edit mid-row
    '{slpm_pkg::FUNC_SUBJECT,    CH_A,  1'b0, 8'd1,  1'b0, 1'b0, 1'b0},
    '{slpm_pkg::FUNC_SUBJECT,    8'h7F, 1'b0, 8'd1,  1'b0, 1'b0, 1'b0},
    '{slpm_pkg::FUNC_EMPTY_ROW,  8'h00, 1'b0, 8'd1,  1'b0, 1'b0, 1'b0},  // empty cuts a row
    '{FUNC_RSVD_FIRST,           8'hFF, 1'b1, 8'd1,  1'b0, 1'b0, 1'b0},  // ignored kinds
    '{FUNC_RSVD_LAST,            8'h00, 1'b0, 8'd1,  1'b0, 1'b0, 1'b0},
    '{slpm_pkg::FUNC_PAT_CLEAR,  8'hFF, 1'b1, 8'd1,  1'b0, 1'b0, 1'b0},  // last ignored here
    // one past full
    '{slpm_pkg::FUNC_PAT_APPEND, slpm_pkg::CH_ANY_ONE, 1'b0, 8'd33, 1'b0, 1'b0, 1'b0},
    '{slpm_pkg::FUNC_EMPTY_ROW,  8'h00, 1'b0, 8'd1,  1'b1, 1'b0, 1'b1},
    '{slpm_pkg::FUNC_SUBJECT,    8'h00, 1'b1, 8'd1,  1'b1, 1'b0, 1'b1},
    '{slpm_pkg::FUNC_PAT_CLEAR,  8'h00, 1'b0, 8'd1,  1'b0, 1'b0, 1'b0},  // drops overflow
    '{slpm_pkg::FUNC_EMPTY_ROW,  8'h00, 1'b0, 8'd1,  1'b1, 1'b1, 1'b0}
  };

  // a live '%' position also makes the next position live
  function automatic logic [PMAX:0] spread_runs(input logic [PMAX:0] pos);
    for (int i = 0; i < pat_len; i++)
      if (pos[i] && pat_mem[i] == slpm_pkg::CH_ANY_RUN) pos[i + 1] = 1'b1;
    return pos;
  endfunction

  function automatic void restart_rows();
    live = '0;
    live[0] = 1'b1;
    live = spread_runs(live);
  endfunction

  // advance the tracker by one accepted beat; returns 1 when a row result is due
  function automatic bit track_beat(input logic [2:0] f, input logic [7:0] d,
                                    input logic l, output slpm_pkg::result_t res);
    logic [PMAX:0] nxt;
    logic          hit;
    logic          known;
    res   = '0;
    hit   = 1'b0;
    known = 1'b1;
    case (f)
      slpm_pkg::FUNC_PAT_APPEND: begin
        if (pat_len < PMAX) begin
          pat_mem[pat_len] = d;
          pat_len++;
        end else begin
          pat_ovf = 1'b1;
        end
        restart_rows();
        return 1'b0;
      end
      slpm_pkg::FUNC_SUBJECT: begin
        nxt = '0;
        for (int i = 0; i < pat_len; i++) begin
          if (live[i]) begin
            if (pat_mem[i] == slpm_pkg::CH_ANY_RUN) nxt[i] = 1'b1;
            else if (pat_mem[i] == slpm_pkg::CH_ANY_ONE || pat_mem[i] == d)
              nxt[i + 1] = 1'b1;
          end
        end
        live = spread_runs(nxt);
        if (!l) return 1'b0;
        hit = live[pat_len];
        restart_rows();
      end
      slpm_pkg::FUNC_EMPTY_ROW: begin
        restart_rows();
        hit = live[pat_len];
      end
      slpm_pkg::FUNC_NULL_ROW: begin
        restart_rows();
        known = 1'b0;
      end
      slpm_pkg::FUNC_PAT_CLEAR: begin
        pat_len = 0;
        pat_ovf = 1'b0;
        restart_rows();
        return 1'b0;
      end
      default: return 1'b0;
    endcase
    // null rows and an overflowed pattern never match, whatever the polarity
    res.matched          = (known && !pat_ovf) ? (hit ^ inv_r) : 1'b0;
    res.pattern_overflow = pat_ovf;
    return 1'b1;
  endfunction

  function automatic logic [7:0] pick_pat_byte();
    int r;
    r = $urandom_range(0, 19);
    if (r < 5) return slpm_pkg::CH_ANY_RUN;
    if (r < 9) return slpm_pkg::CH_ANY_ONE;
    if (r < 17) return CH_A + 8'($urandom_range(0, 1));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_subj_byte();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return CH_A + 8'($urandom_range(0, 1));
    if (r < 14) return slpm_pkg::CH_ANY_RUN;
    return 8'($urandom_range(0, 255));
  endfunction

  // offer one beat after a random gap, wait for the handshake, then predict
  task automatic push_beat(input logic [2:0] f, input logic [7:0] d, input logic l,
                           input logic typed, input slpm_pkg::result_t typed_res);
    int                gap;
    slpm_pkg::result_t res;
    gap = fast_mode ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= d;
    in_tlast  <= l;
    do @(posedge clk); while (in_tready !== 1'b1);
    if (track_beat(f, d, l, res))
      row_results.insert(row_results.size(), typed ? typed_res : res);
    if (f <= slpm_pkg::FUNC_PAT_CLEAR) items_sent++;
  endtask

  // stop offering and wait until every pending row result is out
  task automatic drain_rows();
    in_tvalid <= 1'b0;
    while (row_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // only called with the block idle
  task automatic write_invert(input logic v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    inv_r = v;
  endtask

  // row that ends early on a beat of another kind
  task automatic cut_row();
    logic [2:0] f;
    case ($urandom_range(0, 3))
      0:       f = slpm_pkg::FUNC_PAT_APPEND;
      1:       f = slpm_pkg::FUNC_EMPTY_ROW;
      2:       f = slpm_pkg::FUNC_NULL_ROW;
      default: f = slpm_pkg::FUNC_PAT_CLEAR;
    endcase
    push_beat(f, pick_pat_byte(), 1'($urandom_range(0, 1)), 1'b0, '0);
  endtask

  // well-formed group: a pattern, cleared first nine times in ten, then a few rows, most built to match it
  task automatic run_pattern_group();
    int         r;
    int         plen;
    int         kind;
    int         stop;
    logic [7:0] subj [$];
    if ($urandom_range(0, 9) != 0)
      push_beat(slpm_pkg::FUNC_PAT_CLEAR, 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)), 1'b0, '0);
    r = $urandom_range(0, 99);
    plen = (r < 85) ? $urandom_range(0, 8) :
           (r < 95) ? $urandom_range(9, PMAX) : $urandom_range(PMAX + 1, PMAX + 4);
    repeat (plen) push_beat(slpm_pkg::FUNC_PAT_APPEND, pick_pat_byte(),
                            1'($urandom_range(0, 1)), 1'b0, '0);
    repeat ($urandom_range(1, 6)) begin
      kind = $urandom_range(0, 9);
      subj.delete();
      if (kind <= 6) begin
        for (int i = 0; i < pat_len; i++) begin
          if (pat_mem[i] == slpm_pkg::CH_ANY_RUN)
            repeat ($urandom_range(0, 3)) subj.insert(subj.size(), pick_subj_byte());
          else if (pat_mem[i] == slpm_pkg::CH_ANY_ONE)
            subj.insert(subj.size(), pick_subj_byte());
          else subj.insert(subj.size(), pat_mem[i]);
        end
        // occasional single-byte damage, mostly turns a hit into a miss
        if (subj.size() > 0 && $urandom_range(0, 4) == 0)
          subj[$urandom_range(0, subj.size() - 1)] = pick_subj_byte();
      end else if (kind == 7) begin
        repeat ($urandom_range(1, 6)) subj.insert(subj.size(), pick_subj_byte());
      end
      if (kind == 9) begin
        push_beat(slpm_pkg::FUNC_NULL_ROW, 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), 1'b0, '0);
      end else if (subj.size() == 0) begin
        push_beat(slpm_pkg::FUNC_EMPTY_ROW, 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), 1'b0, '0);
      end else begin
        stop = ($urandom_range(0, 9) == 0) ? $urandom_range(0, subj.size() - 1)
                                           : subj.size();
        for (int i = 0; i < stop; i++)
          push_beat(slpm_pkg::FUNC_SUBJECT, subj[i], 1'(i == subj.size() - 1), 1'b0, '0);
        if (stop < subj.size()) cut_row();
      end
    end
  endtask

  // reset, directed table, then random phases under varying polarity and idling
  initial begin : stimulus
    int                target;
    bit                paused;
    slpm_pkg::result_t typed_res;
    paused = 1'b0;
    pat_len = 0;
    pat_ovf = 1'b0;
    inv_r   = 1'b0;
    restart_rows();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_invert(1'b0);

    for (int k = 0; k < DIR_ROWS; k++) begin
      typed_res.matched          = dir_tbl[k].t_match;
      typed_res.pattern_overflow = dir_tbl[k].t_ovf;
      repeat (dir_tbl[k].reps)
        push_beat(dir_tbl[k].func, dir_tbl[k].data, dir_tbl[k].last,
                  dir_tbl[k].typed, typed_res);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_rows();
      // both polarities first, then random
      write_invert((ph == 0) ? 1'b0 : (ph == 1) ? 1'b1 : 1'($urandom_range(0, 1)));
      fast_mode = (ph == 2) || ($urandom_range(0, 3) == 0);
      if (ph == 3 || ph == 6) hold_req = 1'b1;
      target = items_sent + RAND_ITEMS / NUM_PHASES;
      while (items_sent < target) begin
        // sender pause in the middle of a phase until the pipe is empty
        if (ph == 5 && !paused && items_sent >= target - 120) begin
          drain_rows();
          paused = 1'b1;
        end
        if ($urandom_range(0, 9) < 7) begin
          run_pattern_group();
        end else begin
          // noise: any kind including the ignored ones, random byte and last flag
          push_beat(3'($urandom_range(slpm_pkg::FUNC_PAT_APPEND, FUNC_RSVD_LAST)),
                    8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, '0);
        end
      end
    end

    drain_rows();
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // result receiver: random stalls, one long stall on request, compare each beat
  initial begin : result_sink
    int                gap;
    slpm_pkg::result_t want;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        gap = fast_mode ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
          out_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      if (row_results.size() == 0) begin
        $error("result beat with no row pending: matched %0b pattern_overflow %0b",
               out_tdata[0], out_tuser);
        errors++;
      end else begin
        want = row_results.pop_front();
        if (out_tdata[0] !== want.matched) begin
          $error("matched: expected %0b, got %0b", want.matched, out_tdata[0]);
          errors++;
        end
        if (out_tuser !== want.pattern_overflow) begin
          $error("pattern_overflow: expected %0b, got %0b", want.pattern_overflow,
                 out_tuser);
          errors++;
        end
      end
    end
  end

  // hard stop well past the slowest legal run
  initial begin : watchdog
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
